[sv/flpt_pkg.sv]
// Shared types, codes and constants of the four-level page table engine.
`default_nettype none
package flpt_pkg;

  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned OFS_W            = 12;
  localparam int unsigned ENTRY_W          = 64;
  localparam int unsigned ROOT_W           = 6;

  localparam logic [ENTRY_W-1:0] LINK_BITS = 64'h7;

  localparam logic [1:0] REQ_MAP       = 2'd0;
  localparam logic [1:0] REQ_UNMAP     = 2'd1;
  localparam logic [1:0] REQ_TRANSLATE = 2'd2;
  localparam logic [1:0] REQ_NONE      = 2'd3;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_OUT_OF_PAGES = 2'd1;
  localparam logic [1:0] STATUS_NOT_MAPPED   = 2'd2;

  localparam logic [1:0] LEVEL_TOP  = 2'd0;
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  localparam logic REG_ROOT_PAGE = 1'b0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr_in;
    logic [63:0] entry_flags;
  } flpt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] phys_addr_out;
  } flpt_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ZERO,
    ST_LINK
  } flpt_state_e;

endpackage
`default_nettype wire

[sv/four_level_page_table_engine_top.sv]
// Top level of the four-level page table engine: walk sequencer and register port.
`default_nettype none
// Channel    | Handshake                           | Payload
// -----------+-------------------------------------+-------------------------------
// request    | start && !busy accepts               | req_i  (flpt_req_t)
// result     | done_o, one cycle, cannot be stalled | rsp_o  (flpt_rsp_t)
// config     | psel && penable && pwrite (pready=1) | paddr, pwdata, prdata
//
// Each table level takes a read state and an evaluate state on the single table
// memory port: one issues the read, the other evaluates the entry (and writes the
// leaf at the last level). Busy stays high until the walk ends, and the result is
// strobed in the cycle after. Every intermediate table that map allocates adds a
// clear of all 512 entries of the new page and the link write.
// Reset starts a clearing pass over all TABLE_PAGES * 512 entries, one entry a
// cycle, with busy high; configuration writes are taken throughout.
// Request type 3 and a root page outside the pool answer in the next cycle.
module four_level_page_table_engine_top #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire flpt_pkg::flpt_req_t req_i,
  output logic                     done_o,
  output flpt_pkg::flpt_rsp_t      rsp_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);
  import flpt_pkg::*;

  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned NW    = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AW    = PW + IDX_W;
  localparam int unsigned DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;

  flpt_state_e state_q, state_d;

  flpt_req_t          req_q, req_d;
  logic [1:0]         level_q, level_d;
  logic [PW-1:0]      page_q, page_d;
  logic [PW-1:0]      fresh_q, fresh_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [NW-1:0]      nfp_q, nfp_d;
  logic [ROOT_W-1:0]  root_page_q, root_page_d;
  flpt_rsp_t          rsp_q, rsp_d;
  logic               done_q, done_d;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               accept;
  logic [31:0]        root_ext;
  logic               root_ok;
  logic               link_ok;
  logic [PW-1:0]      link_pg;
  logic               pool_full;
  logic [IDX_W-1:0]   lvl_idx;
  logic               clear_last;
  logic               zero_last;
  logic               cfg_wr;

  flpt_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Shared decode of the walk.
  assign accept     = start && !busy;
  assign root_ext   = 32'(root_page_q);
  assign root_ok    = root_ext < TABLE_PAGES;
  assign link_ok    = mem_rdata[0] && (mem_rdata[63:12] < 52'(TABLE_PAGES));
  assign link_pg    = mem_rdata[OFS_W +: PW];
  assign pool_full  = nfp_q >= NW'(TABLE_PAGES);
  assign clear_last = clr_q == AW'(DEPTH - 1);
  assign zero_last  = clr_q[IDX_W-1:0] == IDX_W'(ENTRIES_PER_PAGE - 1);

  // Pick the entry index of the current level from the virtual address.
  always_comb begin
    unique case (level_q)
      2'd0:    lvl_idx = req_q.virt_addr[47:39];
      2'd1:    lvl_idx = req_q.virt_addr[38:30];
      2'd2:    lvl_idx = req_q.virt_addr[29:21];
      default: lvl_idx = req_q.virt_addr[20:12];
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (req_i.req_type != REQ_NONE) && root_ok) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (level_q != LEVEL_LEAF) begin
          priority if (link_ok) begin
            state_d = ST_READ;
          end else if ((req_q.req_type == REQ_MAP) && !pool_full) begin
            state_d = ST_ZERO;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (zero_last) state_d = ST_LINK;
      end
      ST_LINK: state_d = ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port, walk registers and result.
  always_comb begin
    req_d     = req_q;
    level_d   = level_q;
    page_d    = page_q;
    fresh_d   = fresh_q;
    clr_d     = clr_q;
    nfp_d     = nfp_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {page_q, lvl_idx};
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clear_last ? '0 : clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          req_d   = req_i;
          level_d = LEVEL_TOP;
          page_d  = root_ext[PW-1:0];
          rsp_d.phys_addr_out = '0;
          // Answer at once: unused type, or a root outside the pool.
          if (req_i.req_type == REQ_NONE) begin
            done_d       = 1'b1;
            rsp_d.status = STATUS_OK;
          end else if (!root_ok) begin
            done_d = 1'b1;
            unique case (req_i.req_type)
              REQ_MAP:       rsp_d.status = STATUS_OUT_OF_PAGES;
              REQ_TRANSLATE: rsp_d.status = STATUS_NOT_MAPPED;
              default:       rsp_d.status = STATUS_OK;
            endcase
          end
        end
      end
      ST_READ: begin
        // Address already selects the current level's entry.
      end
      ST_EVAL: begin
        if (level_q != LEVEL_LEAF) begin
          priority if (link_ok) begin
            page_d  = link_pg;
            level_d = level_q + 1'b1;
          end else if ((req_q.req_type == REQ_MAP) && !pool_full) begin
            fresh_d = nfp_q[PW-1:0];
            nfp_d   = nfp_q + 1'b1;
            clr_d   = '0;
          end else begin
            done_d              = 1'b1;
            rsp_d.phys_addr_out = '0;
            unique case (req_q.req_type)
              REQ_MAP:       rsp_d.status = STATUS_OUT_OF_PAGES;
              REQ_TRANSLATE: rsp_d.status = STATUS_NOT_MAPPED;
              default:       rsp_d.status = STATUS_OK;
            endcase
          end
        end else begin
          done_d              = 1'b1;
          rsp_d.status        = STATUS_OK;
          rsp_d.phys_addr_out = '0;
          unique case (req_q.req_type)
            REQ_MAP: begin
              mem_we    = 1'b1;
              mem_wdata = {12'b0, req_q.phys_addr_in[51:12], 12'b0} | req_q.entry_flags;
            end
            REQ_UNMAP: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            REQ_TRANSLATE: begin
              if (mem_rdata[0]) begin
                rsp_d.phys_addr_out = {mem_rdata[63:12], req_q.virt_addr[11:0]};
              end else begin
                rsp_d.status = STATUS_NOT_MAPPED;
              end
            end
            default: begin
              rsp_d.status = STATUS_OK;
            end
          endcase
        end
      end
      ST_ZERO: begin
        // Clear the new page before anything points to it.
        mem_we   = 1'b1;
        mem_addr = {fresh_q, clr_q[IDX_W-1:0]};
        clr_d    = clr_q + 1'b1;
      end
      ST_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = (ENTRY_W'(fresh_q) << OFS_W) | LINK_BITS;
        page_d    = fresh_q;
        level_d   = level_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Register port: root page only, writes decoded by word index.
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    root_page_d = root_page_q;
    if (cfg_wr && (paddr[2] == REG_ROOT_PAGE)) begin
      root_page_d = pwdata[ROOT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_ROOT_PAGE) ? 32'(root_page_q) : '0;
  assign pready = 1'b1;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      nfp_q       <= NW'(1);
      root_page_q <= '0;
      done_q      <= 1'b0;
      level_q     <= LEVEL_TOP;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      nfp_q       <= nfp_d;
      root_page_q <= root_page_d;
      done_q      <= done_d;
      level_q     <= level_d;
    end
  end

  // Payload of the walk and the result.
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    page_q  <= page_d;
    fresh_q <= fresh_d;
    rsp_q   <= rsp_d;
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // The allocator never hands out a page beyond the pool.
  a_nfp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfp_q <= NW'(TABLE_PAGES))
    else $error("allocator ran past the pool");

  // An accepted transaction either starts a walk or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction dropped");

  // A result is only strobed once the walk has ended.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed during a walk");

  // A link entry is only written right after the new page was cleared.
  a_link_after_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> ($past(state_q) == ST_ZERO))
    else $error("link written without clearing the page");
`endif

endmodule
`default_nettype wire

[sv/flpt_table_ram.sv]
// Single-port table memory with a registered read, one access per cycle.
`default_nettype none
module flpt_table_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 addr_i,
  input  wire logic [flpt_pkg::ENTRY_W-1:0]  wdata_i,
  output logic      [flpt_pkg::ENTRY_W-1:0]  rdata_o
);
  import flpt_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
